[src/lgm_pkg.sv]
// Shared widths, constants and the limiter curve table for the gate mixer limiter.
package lgm_pkg;

    localparam int TRACKS    = 8;
    localparam int TRK_W     = 3;
    localparam int SMP_W     = 24;
    localparam int LIM_W     = 22;
    localparam int SUM_W     = 28;
    localparam int LVL_W     = 21;
    localparam int DEC_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 21;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_DECAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ENABLE = 2'd2;

    localparam logic [LVL_W-1:0]  GATE_LEVEL_RST = 21'd331;
    localparam logic [DEC_W-1:0]  GATE_DECAY_RST = 16'd65522;
    localparam logic [GAIN_W-1:0] GAIN_ONE       = 16'd32768;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 28'sh7FFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 28'sh8000000;

    // round(524288 * tanh(k / 4)), k = 0..32
    function automatic logic [19:0] lgm_tanh(input logic [5:0] k);
        logic [19:0] v;
        begin
            case (k)
                6'd0:  v = 20'd0;
                6'd1:  v = 20'd128408;
                6'd2:  v = 20'd242282;
                6'd3:  v = 20'd333001;
                6'd4:  v = 20'd399295;
                6'd5:  v = 20'd444745;
                6'd6:  v = 20'd474558;
                6'd7:  v = 20'd493552;
                6'd8:  v = 20'd505428;
                6'd9:  v = 20'd512767;
                6'd10: v = 20'd517270;
                6'd11: v = 20'd520020;
                6'd12: v = 20'd521695;
                6'd13: v = 20'd522714;
                6'd14: v = 20'd523333;
                6'd15: v = 20'd523708;
                6'd16: v = 20'd523936;
                6'd17: v = 20'd524075;
                6'd18: v = 20'd524159;
                6'd19: v = 20'd524210;
                6'd20: v = 20'd524240;
                6'd21: v = 20'd524259;
                6'd22: v = 20'd524270;
                6'd23: v = 20'd524277;
                6'd24: v = 20'd524282;
                6'd25: v = 20'd524284;
                6'd26: v = 20'd524286;
                6'd27: v = 20'd524287;
                6'd28: v = 20'd524287;
                6'd29: v = 20'd524287;
                default: v = 20'd524288;
            endcase
            return v;
        end
    endfunction

    // saturate a grown sum back to the accumulator width
    function automatic logic signed [SUM_W-1:0] lgm_sat(input logic signed [29:0] s);
        logic signed [SUM_W-1:0] v;
        begin
            if (s > 30'(SUM_MAX)) begin
                v = SUM_MAX;
            end else if (s < 30'(SUM_MIN)) begin
                v = SUM_MIN;
            end else begin
                v = s[SUM_W-1:0];
            end
            return v;
        end
    endfunction

endpackage

[src/lgm_in_if.sv]
// Input channel: one track word per handshake.
interface lgm_in_if;
    import lgm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [TRK_W-1:0]         track;
    logic                     last_track;
    logic                     present;
    logic                     tx_on;
    logic signed [SMP_W-1:0]  sample_left;
    logic signed [SMP_W-1:0]  sample_right;
    logic signed [SMP_W-1:0]  loop_left;
    logic signed [SMP_W-1:0]  loop_right;

    modport source (output valid, track, last_track, present, tx_on, sample_left,
                    sample_right, loop_left, loop_right, input ready);
    modport sink (input valid, track, last_track, present, tx_on, sample_left,
                  sample_right, loop_left, loop_right, output ready);
endinterface

[src/lgm_out_if.sv]
// Output channel: direct outs and frame mix/cue, one word per handshake.
interface lgm_out_if;
    import lgm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  direct_left;
    logic signed [SMP_W-1:0]  direct_right;
    logic                     frame_done;
    logic signed [LIM_W-1:0]  mix_left;
    logic signed [LIM_W-1:0]  mix_right;
    logic signed [LIM_W-1:0]  cue_left;
    logic signed [LIM_W-1:0]  cue_right;

    modport source (output valid, direct_left, direct_right, frame_done, mix_left,
                    mix_right, cue_left, cue_right, input ready);
    modport sink (input valid, direct_left, direct_right, frame_done, mix_left,
                  mix_right, cue_left, cue_right, output ready);
endinterface

[src/live_thru_gate_mixer_limiter_top.sv]
// A track word runs through gain, multiply and accumulate (and the limiter on a frame's
// last track) into the output register, which must be loaded before a new word is taken.
// A bit-serial multiply loop runs the envelope decay and the four gain products.
// On a last track the four sums share the single limiter interpolation multiplier in turn.
// Synchronous active-low reset clears envelopes, gains, sums and the config to defaults.
module live_thru_gate_mixer_limiter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lgm_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    lgm_in_if.sink                         i_in,
    lgm_out_if.source                      o_out
);
    import lgm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GAIN = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_LIM  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_st;

    // configuration
    logic [LVL_W-1:0] r_gate_level;
    logic [DEC_W-1:0] r_gate_decay;
    logic             r_mix_en;

    // per-track state
    logic [SMP_W-1:0]  r_env  [TRACKS];
    logic [GAIN_W-1:0] r_gain [TRACKS];

    // frame sums
    logic signed [SUM_W-1:0] r_msl, r_msr, r_csl, r_csr;

    // captured word
    logic [TRK_W-1:0]        r_trk;
    logic                    r_trk_ok, r_last, r_tx;
    logic signed [SMP_W-1:0] r_l, r_r, r_lpl, r_lpr;

    // serial multiply
    logic [3:0]              r_cnt;
    logic [SMP_W-1:0]        r_peak;
    logic [SMP_W-1:0]        r_env_op;
    logic [GAIN_W-1:0]       r_g;
    logic [DEC_W-1:0]        r_dsh;
    logic [GAIN_W-1:0]       r_gsh, r_hsh;
    logic [39:0]             r_pe;
    logic signed [40:0]      r_pml, r_pmr, r_pcl, r_pcr;
    logic [1:0]              r_li;

    // staged result and output register
    logic signed [SMP_W-1:0] r_dl, r_dr;
    logic signed [LIM_W-1:0] r_ml, r_mr, r_cl, r_cr;
    logic                    r_ov, r_ofd;
    logic signed [SMP_W-1:0] r_odl, r_odr;
    logic signed [LIM_W-1:0] r_oml, r_omr, r_ocl, r_ocr;

    // gain step toward the tx target
    logic [GAIN_W-1:0]       g_old;
    logic signed [17:0]      g_tgt, g_dlt, g_new, g_rem;
    logic signed [25:0]      g_prod;
    logic signed [17:0]      g_stp;
    logic [SMP_W-1:0]        a_l, a_r;

    always_comb begin
        g_old  = r_gain[r_trk];
        g_tgt  = r_tx ? 18'sd32768 : 18'sd0;
        g_dlt  = g_tgt - $signed({2'b00, g_old});
        g_prod = ($signed({{8{g_dlt[17]}}, g_dlt}) <<< 7)
               + ($signed({{8{g_dlt[17]}}, g_dlt}) <<< 1)
               + $signed({{8{g_dlt[17]}}, g_dlt}) + 26'sd32768;
        g_stp  = 18'(g_prod >>> 16);
        if (g_stp == 18'sd0 && g_dlt != 18'sd0) begin
            g_stp = (g_dlt > 18'sd0) ? 18'sd1 : -18'sd1;
        end
        g_new  = $signed({2'b00, g_old}) + g_stp;
        g_rem  = g_tgt - g_new;
        if (g_rem <= 18'sd3 && g_rem >= -18'sd3) begin
            g_new = g_tgt;
        end
        a_l = r_l[SMP_W-1] ? SMP_W'(-r_l) : r_l;
        a_r = r_r[SMP_W-1] ? SMP_W'(-r_r) : r_r;
    end

    // envelope update, gate, rounding and accumulation
    logic [SMP_W-1:0]        env_dec, env_new;
    logic                    gate;
    logic signed [40:0]      rnd_ml, rnd_mr, rnd_cl, rnd_cr;
    logic signed [25:0]      sh_ml, sh_mr, sh_cl, sh_cr;
    logic signed [SMP_W-1:0] tl, tr;
    logic signed [SMP_W:0]   d_l, d_r;
    logic signed [SMP_W-1:0] dsat_l, dsat_r;

    function automatic logic signed [29:0] grow(input logic signed [SUM_W-1:0] s,
                                                input logic signed [25:0] p,
                                                input logic signed [SMP_W-1:0] q);
        return {{2{s[SUM_W-1]}}, s} + {{4{p[25]}}, p} + {{6{q[SMP_W-1]}}, q};
    endfunction

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [SMP_W:0] v);
        logic signed [SMP_W-1:0] o;
        begin
            if (v > 25'sd8388607) begin
                o = 24'sh7FFFFF;
            end else if (v < -25'sd8388608) begin
                o = 24'sh800000;
            end else begin
                o = v[SMP_W-1:0];
            end
            return o;
        end
    endfunction

    always_comb begin
        env_dec = r_pe[39:16];
        env_new = (r_peak > env_dec) ? r_peak : env_dec;
        gate    = env_new >= {3'b000, r_gate_level};
        rnd_ml  = r_pml + 41'sd16384;
        rnd_mr  = r_pmr + 41'sd16384;
        rnd_cl  = r_pcl + 41'sd16384;
        rnd_cr  = r_pcr + 41'sd16384;
        sh_ml   = gate ? rnd_ml[40:15] : 26'sd0;
        sh_mr   = gate ? rnd_mr[40:15] : 26'sd0;
        sh_cl   = gate ? rnd_cl[40:15] : 26'sd0;
        sh_cr   = gate ? rnd_cr[40:15] : 26'sd0;
        tl      = gate ? r_l : '0;
        tr      = gate ? r_r : '0;
        d_l     = {r_lpl[SMP_W-1], r_lpl} + {tl[SMP_W-1], tl};
        d_r     = {r_lpr[SMP_W-1], r_lpr} + {tr[SMP_W-1], tr};
        dsat_l  = sat24(d_l);
        dsat_r  = sat24(d_r);
    end

    // soft limiter on one sum per cycle
    logic signed [SUM_W-1:0] lx;
    logic [SUM_W-1:0]        lax, ld;
    logic [5:0]              lidx;
    logic [16:0]             lfrac, ldiff;
    logic [19:0]             llo, lhi;
    logic [33:0]             lprod;
    logic [20:0]             le;
    logic [21:0]             ly;
    logic signed [LIM_W-1:0] lout;

    always_comb begin
        case (r_li)
            2'd0:    lx = r_msl;
            2'd1:    lx = r_msr;
            2'd2:    lx = r_csl;
            default: lx = r_csr;
        endcase
        lax   = lx[SUM_W-1] ? SUM_W'(-lx) : lx;
        ld    = lax - 28'd1048576;
        lidx  = ld[22:17];
        lfrac = ld[16:0];
        llo   = lgm_tanh(lidx);
        lhi   = lgm_tanh(lidx + 6'd1);
        ldiff = 17'(lhi - llo);
        lprod = ldiff * lfrac + 34'd65536;
        if (ld[SUM_W-1:22] != '0) begin
            le = 21'd524288;
        end else begin
            le = {1'b0, llo} + 21'(lprod[33:17]);
        end
        ly = 22'd1048576 + {1'b0, le};
        if (lax <= 28'd1048576) begin
            lout = lx[LIM_W-1:0];
        end else begin
            lout = lx[SUM_W-1] ? $signed(-ly) : $signed(ly);
        end
    end

    logic in_acc, out_acc;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_gate_level <= GATE_LEVEL_RST;
            r_gate_decay <= GATE_DECAY_RST;
            r_mix_en     <= 1'b1;
            r_msl        <= '0;
            r_msr        <= '0;
            r_csl        <= '0;
            r_csr        <= '0;
            r_cnt        <= '0;
            r_li         <= '0;
            r_ov         <= 1'b0;
            for (int i = 0; i < TRACKS; i++) begin
                r_env[i]  <= '0;
                r_gain[i] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GATE_LEVEL: r_gate_level <= i_cfg_data[LVL_W-1:0];
                    CFG_GATE_DECAY: r_gate_decay <= i_cfg_data[DEC_W-1:0];
                    CFG_MIX_ENABLE: r_mix_en     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // output word taken; S_OUT reloads the register itself
            if (out_acc && r_st != S_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_trk    <= i_in.track;
                        r_trk_ok <= 32'(i_in.track) < TRACKS;
                        r_last   <= i_in.last_track;
                        r_tx     <= i_in.tx_on;
                        r_l      <= i_in.present ? i_in.sample_left : '0;
                        r_r      <= i_in.present ? i_in.sample_right : '0;
                        r_lpl    <= i_in.loop_left;
                        r_lpr    <= i_in.loop_right;
                        r_st     <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_g      <= g_new[GAIN_W-1:0];
                    r_gsh    <= g_new[GAIN_W-1:0];
                    r_hsh    <= GAIN_ONE - g_new[GAIN_W-1:0];
                    r_dsh    <= r_gate_decay;
                    r_env_op <= r_env[r_trk];
                    r_peak   <= (a_l > a_r) ? a_l : a_r;
                    r_pe     <= '0;
                    r_pml    <= '0;
                    r_pmr    <= '0;
                    r_pcl    <= '0;
                    r_pcr    <= '0;
                    r_cnt    <= '0;
                    r_st     <= S_MUL;
                end
                S_MUL: begin
                    // one multiplier bit per cycle, MSB first
                    r_pe  <= (r_pe << 1) + (r_dsh[DEC_W-1] ? {16'd0, r_env_op} : 40'd0);
                    r_pml <= (r_pml <<< 1) + (r_gsh[GAIN_W-1] ? 41'(r_l) : 41'sd0);
                    r_pmr <= (r_pmr <<< 1) + (r_gsh[GAIN_W-1] ? 41'(r_r) : 41'sd0);
                    r_pcl <= (r_pcl <<< 1) + (r_hsh[GAIN_W-1] ? 41'(r_l) : 41'sd0);
                    r_pcr <= (r_pcr <<< 1) + (r_hsh[GAIN_W-1] ? 41'(r_r) : 41'sd0);
                    r_dsh <= r_dsh << 1;
                    r_gsh <= r_gsh << 1;
                    r_hsh <= r_hsh << 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_cnt <= '0;
                        r_st  <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_trk_ok) begin
                        r_env[r_trk]  <= env_new;
                        r_gain[r_trk] <= r_g;
                        if (r_mix_en) begin
                            r_msl <= lgm_sat(grow(r_msl, sh_ml, r_lpl));
                            r_msr <= lgm_sat(grow(r_msr, sh_mr, r_lpr));
                        end
                        r_csl <= lgm_sat(grow(r_csl, sh_cl, '0));
                        r_csr <= lgm_sat(grow(r_csr, sh_cr, '0));
                        r_dl  <= dsat_l;
                        r_dr  <= dsat_r;
                    end else begin
                        r_dl <= '0;
                        r_dr <= '0;
                    end
                    r_ml <= '0;
                    r_mr <= '0;
                    r_cl <= '0;
                    r_cr <= '0;
                    r_li <= '0;
                    r_st <= r_last ? S_LIM : S_OUT;
                end
                S_LIM: begin
                    case (r_li)
                        2'd0:    r_ml <= r_mix_en ? lout : '0;
                        2'd1:    r_mr <= r_mix_en ? lout : '0;
                        2'd2:    r_cl <= lout;
                        default: r_cr <= lout;
                    endcase
                    r_li <= r_li + 2'd1;
                    if (r_li == 2'd3) begin
                        r_msl <= '0;
                        r_msr <= '0;
                        r_csl <= '0;
                        r_csr <= '0;
                        r_st  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov  <= 1'b1;
                        r_odl <= r_dl;
                        r_odr <= r_dr;
                        r_ofd <= r_last;
                        r_oml <= r_ml;
                        r_omr <= r_mr;
                        r_ocl <= r_cl;
                        r_ocr <= r_cr;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_st == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.direct_left  = r_odl;
    assign o_out.direct_right = r_odr;
    assign o_out.frame_done   = r_ofd;
    assign o_out.mix_left     = r_oml;
    assign o_out.mix_right    = r_omr;
    assign o_out.cue_left     = r_ocl;
    assign o_out.cue_right    = r_ocr;

`ifndef SYNTHESIS
    a_accept_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_st == S_GAIN)
        else $error("accepted word did not start gain step");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_MUL |-> r_cnt == 4'd0)
        else $error("multiply counter running outside multiply loop");
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LIM && r_li == 2'd3) |=>
            (r_msl == '0 && r_msr == '0 && r_csl == '0 && r_csr == '0))
        else $error("frame sums not cleared at frame end");
    a_no_mix_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ofd) |-> (r_oml == '0 && r_omr == '0 && r_ocl == '0 && r_ocr == '0))
        else $error("mix or cue nonzero outside frame end");
`endif

endmodule
